// ----- rtl/adc_reading_calibration_unit_assert.svh -----
// Assertion macros for the ADC reading calibration unit.
// Used by adc_reading_calibration_unit.sv; expects clk and rst in scope.
`ifndef ADC_READING_CALIBRATION_UNIT_ASSERT_SVH
`define ADC_READING_CALIBRATION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/acu_pkg.sv -----
// Shared widths, register indexes and reset values for the calibration unit.
// No dependencies.
package acu_pkg;

  localparam int ADC_W         = 24;  // raw converter word
  localparam int GAIN_W        = 24;  // gain divisor register
  localparam int OFS_W         = 16;  // zero correction register
  localparam int OUT_W         = 16;  // calibrated reading
  localparam int IN_SHIFT      = 5;
  localparam int VAL_W         = ADC_W + 1;          // signed corrected value
  localparam int V_W           = ADC_W - IN_SHIFT;   // shifted positive value
  localparam int FRAC_BITS_DEF = 16;
  localparam int RND_NUM       = 10;  // round up when 10 * r >= 6 * d
  localparam int RND_DEN       = 6;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(65536);
  localparam logic [OFS_W-1:0]  ZERO_RST = '0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_DIVISOR    = 1'b0,
    REG_ZERO_CORRECTION = 1'b1
  } cfg_reg_t;

endpackage

// ----- rtl/adc_reading_calibration_unit.sv -----
// Throughput: one request per cycle unless the output stalls; a 16-step
// restoring divider runs one quotient bit per pipeline stage, so every stage
// can hold a different word.
// A stalled output only blocks stages that are full; bubbles fill up first.
// Reset (synchronous): all stage valids clear, gain 1.0, zero correction 0.
//
// Depends on acu_pkg and adc_reading_calibration_unit_assert.svh.
`include "adc_reading_calibration_unit_assert.svh"

module adc_reading_calibration_unit
  import acu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADC_W-1:0]      s_tdata,   // [23:0] adc_raw
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // [15:0] reading
  output logic                  m_tuser    // [0] clipped
);

  localparam int Q_W          = OUT_W;
  localparam int NUM_W        = V_W + FRAC_BITS;
  localparam int HI_W         = NUM_W - Q_W;
  localparam int CMP_W        = (HI_W > GAIN_W) ? HI_W : GAIN_W;
  localparam int RND_W        = GAIN_W + 4;
  localparam int ST_MAG       = 0;
  localparam int ST_PRE       = 1;
  localparam int ST_DIV_LAST  = ST_PRE + Q_W;
  localparam int ST_RND       = ST_DIV_LAST + 1;
  localparam int ST_OUT       = ST_RND + 1;
  localparam int NS           = ST_OUT + 1;

  // configuration registers
  logic [GAIN_W-1:0] gain;
  logic [OFS_W-1:0]  zero_corr;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RST;
      zero_corr <= ZERO_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GAIN_DIVISOR:    gain      <= cfg_wdata[GAIN_W-1:0];
        REG_ZERO_CORRECTION: zero_corr <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage flow control
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[ST_MAG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[ST_MAG]) begin
        vld[ST_MAG] <= s_tvalid;
      end
      for (int i = ST_MAG + 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage payloads
  logic                zro [ST_MAG:ST_RND];
  logic                ovf [ST_PRE:ST_RND];
  logic [V_W-1:0]      v_s0;
  logic [GAIN_W-1:0]   rem [ST_PRE:ST_DIV_LAST];
  logic [Q_W-1:0]      quo [ST_PRE:ST_RND];
  logic [Q_W-1:0]      lo  [ST_PRE:ST_DIV_LAST];
  logic                rnd;
  logic [OUT_W-1:0]    out_reading;
  logic                out_clipped;

  // stage 0: magnitude and zero correction
  logic [ADC_W-1:0] mag;
  logic [VAL_W-1:0] val;

  always_comb begin
    mag = s_tdata[ADC_W-1] ? ({1'b0, ~s_tdata[ADC_W-2:0]} + ADC_W'(1)) : s_tdata;
    if (zero_corr[OFS_W-1]) begin
      val = {1'b0, mag} - VAL_W'(zero_corr[OFS_W-2:0]);
    end else begin
      val = {1'b0, mag} + VAL_W'(zero_corr);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_MAG]) begin
      zro[ST_MAG] <= val[VAL_W-1] || (val == '0);
      v_s0        <= val[VAL_W-2:IN_SHIFT];
    end
  end

  // stage 1: scale to fixed point, overflow check, initial remainder
  logic [NUM_W-1:0] num;
  logic [HI_W-1:0]  num_hi;

  assign num    = {v_s0, {FRAC_BITS{1'b0}}};
  assign num_hi = num[NUM_W-1:Q_W];

  always_ff @(posedge clk) begin
    if (rdy[ST_PRE]) begin
      zro[ST_PRE] <= zro[ST_MAG];
      // quotient needs more than Q_W bits (also catches a zero divisor)
      ovf[ST_PRE] <= CMP_W'(num_hi) >= CMP_W'(gain);
      rem[ST_PRE] <= GAIN_W'(num_hi);
      lo[ST_PRE]  <= num[Q_W-1:0];
      quo[ST_PRE] <= '0;
    end
  end

  // stages 2..17: one restoring division step each
  for (genvar k = ST_PRE + 1; k <= ST_DIV_LAST; k++) begin : g_div
    logic [GAIN_W:0] sh;
    logic            ge;

    assign sh = {rem[k-1], lo[k-1][Q_W-1]};
    assign ge = sh >= {1'b0, gain};

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        zro[k] <= zro[k-1];
        ovf[k] <= ovf[k-1];
        rem[k] <= ge ? GAIN_W'(sh - {1'b0, gain}) : sh[GAIN_W-1:0];
        quo[k] <= {quo[k-1][Q_W-2:0], ge};
        lo[k]  <= {lo[k-1][Q_W-2:0], 1'b0};
      end
    end
  end

  // stage 18: rounding decision at fraction 0.6
  always_ff @(posedge clk) begin
    if (rdy[ST_RND]) begin
      zro[ST_RND] <= zro[ST_DIV_LAST];
      ovf[ST_RND] <= ovf[ST_DIV_LAST];
      quo[ST_RND] <= quo[ST_DIV_LAST];
      rnd <= (RND_W'(rem[ST_DIV_LAST]) * RND_W'(RND_NUM)) >=
             (RND_W'(gain) * RND_W'(RND_DEN));
    end
  end

  // stage 19: increment and saturate
  logic [Q_W:0] q_inc;
  logic         sat;

  assign q_inc = {1'b0, quo[ST_RND]} + (Q_W+1)'(rnd);
  assign sat   = ovf[ST_RND] || q_inc[Q_W];

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      if (zro[ST_RND]) begin
        out_reading <= '0;
        out_clipped <= 1'b0;
      end else if (sat) begin
        out_reading <= '1;
        out_clipped <= 1'b1;
      end else begin
        out_reading <= q_inc[Q_W-1:0];
        out_clipped <= 1'b0;
      end
    end
  end

  assign m_tvalid = vld[ST_OUT];
  assign m_tdata  = out_reading;
  assign m_tuser  = out_clipped;

  // checks
  `ACU_ASSERT_NOW(a_clip_full_scale, m_tvalid && m_tuser, m_tdata == '1,
                  "clipped reading is not full scale")
  `ACU_ASSERT_NOW(a_rem_below_div,
                  vld[ST_DIV_LAST] && !zro[ST_DIV_LAST] && !ovf[ST_DIV_LAST],
                  rem[ST_DIV_LAST] < gain, "division remainder not below divisor")
  `ACU_ASSERT_NOW(a_stall_only_full, !s_tready, vld == '1,
                  "input stalled while pipeline has a bubble")
  `ACU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output changed")

endmodule
